FILE: hw/rtl/greedy_rectangle_overlap_filter_defines.svh
// ----------------------------------------------------------------------------
// greedy_rectangle_overlap_filter_defines
// Assertion macros shared by the checker of the overlap filter.
// ----------------------------------------------------------------------------
`ifndef GREEDY_RECTANGLE_OVERLAP_FILTER_DEFINES_SVH
`define GREEDY_RECTANGLE_OVERLAP_FILTER_DEFINES_SVH

// clocked property, masked while reset is asserted
`define GROF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define GROF_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/grof_pkg.sv
// ----------------------------------------------------------------------------
// grof_pkg
// Types and constants of the greedy rectangle overlap filter.
// ----------------------------------------------------------------------------
package grof_pkg;

    localparam int MAX_RECTS = 1024;
    localparam int ADDR_W    = $clog2(MAX_RECTS);
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECTS);

    localparam int COORD_W = 32;
    localparam int TOL_W   = 31;
    localparam int IDX_W   = 10;

    localparam int QDEPTH = 2;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_X_TOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TOL = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_low;
        logic signed [COORD_W-1:0] x_high;
        logic signed [COORD_W-1:0] y_low;
        logic signed [COORD_W-1:0] y_high;
    } t_bounds;

    localparam int BOUNDS_W = $bits(t_bounds);

    typedef struct packed {
        t_bounds          bounds;
        logic [IDX_W-1:0] rect_index;
        logic             last_of_set;
    } t_rect;

    typedef struct packed {
        logic  valid;
        t_rect rect;
    } t_q_out;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_RESULT
    } t_back_state;

endpackage

FILE: hw/rtl/grof_ram.sv
// ----------------------------------------------------------------------------
// grof_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module grof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

FILE: hw/rtl/grof_front.sv
// ----------------------------------------------------------------------------
// grof_front
// Input side: takes rectangles from the input channel into a short queue
// that the scan engine drains.
// ----------------------------------------------------------------------------
module grof_front import grof_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_rect  i_rect,
    output t_q_out o_q,
    input  logic   i_pop
);

    t_rect            r_mem [QDEPTH];
    logic [QP_W-1:0]  r_wp, n_wp;
    logic [QP_W-1:0]  r_rp, n_rp;
    logic [QC_W-1:0]  r_cnt, n_cnt;
    logic             push;
    logic             pop;

    assign o_stall = (r_cnt == QC_W'(QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    assign o_q.valid = (r_cnt != '0);
    assign o_q.rect  = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_rect;
        end
    end

endmodule

FILE: hw/rtl/grof_back.sv
// ----------------------------------------------------------------------------
// grof_back
// Scan engine: compares one rectangle against the kept store, one entry a
// cycle, then stores it if kept and the store has room, and registers the result.
// ----------------------------------------------------------------------------
module grof_back import grof_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_out           i_q,
    output logic             o_pop,
    input  logic [TOL_W-1:0] i_x_tol,
    input  logic [TOL_W-1:0] i_y_tol,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_result_index,
    output logic             o_keep,
    output logic             o_store_full
);

    t_back_state      r_state, n_state;
    t_rect            r_item, n_item;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pend, n_pend;
    logic             r_keep, n_keep;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_index, n_out_index;
    logic             r_out_keep, n_out_keep;
    logic             r_out_full, n_out_full;

    logic             wr_en;
    t_bounds          rd_data;
    logic [BOUNDS_W-1:0] rd_raw;

    logic signed [COORD_W:0] d_x0, d_x1, d_y0, d_y1;
    logic signed [COORD_W:0] tol_x, tol_y;
    logic             overlap;
    logic             hit;
    logic             scan_done;
    logic             out_free;
    logic             can_store;

    grof_ram #(
        .WIDTH (BOUNDS_W),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_item.bounds),
        .i_rd_addr (r_k[ADDR_W-1:0]),
        .o_rd_data (rd_raw)
    );

    assign rd_data = t_bounds'(rd_raw);

    // separate on an axis if either gap exceeds the tolerance
    assign tol_x = $signed({2'b00, i_x_tol});
    assign tol_y = $signed({2'b00, i_y_tol});
    assign d_x0  = {r_item.bounds.x_low[COORD_W-1], r_item.bounds.x_low}
                 - {rd_data.x_high[COORD_W-1], rd_data.x_high};
    assign d_x1  = {rd_data.x_low[COORD_W-1], rd_data.x_low}
                 - {r_item.bounds.x_high[COORD_W-1], r_item.bounds.x_high};
    assign d_y0  = {r_item.bounds.y_low[COORD_W-1], r_item.bounds.y_low}
                 - {rd_data.y_high[COORD_W-1], rd_data.y_high};
    assign d_y1  = {rd_data.y_low[COORD_W-1], rd_data.y_low}
                 - {r_item.bounds.y_high[COORD_W-1], r_item.bounds.y_high};
    assign overlap = !((d_x0 > tol_x) || (d_x1 > tol_x)
                    || (d_y0 > tol_y) || (d_y1 > tol_y));

    assign hit       = r_pend && overlap;
    assign scan_done = hit || (r_k == r_count);
    assign out_free  = !r_out_valid || !i_stall;
    assign can_store = r_keep && (r_count != MAX_CNT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q.valid) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (scan_done) begin
                    n_state = BK_RESULT;
                end
            end
            BK_RESULT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        n_item      = r_item;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_keep      = r_keep;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out_index = r_out_index;
        n_out_keep  = r_out_keep;
        n_out_full  = r_out_full;
        unique case (r_state)
            BK_IDLE: begin
                o_pop  = i_q.valid;
                n_item = i_q.rect;
                n_k    = '0;
                n_keep = 1'b1;
            end
            BK_SCAN: begin
                if (r_k != r_count) begin
                    n_k    = r_k + 1'b1;
                    n_pend = 1'b1;
                end
                if (hit) begin
                    n_keep = 1'b0;
                end
            end
            BK_RESULT: begin
                if (out_free) begin
                    wr_en       = can_store;
                    n_out_valid = 1'b1;
                    n_out_index = r_item.rect_index;
                    n_out_keep  = r_keep;
                    n_out_full  = r_keep && !can_store;
                    if (r_item.last_of_set) begin
                        n_count = '0;
                    end else if (can_store) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_k         <= n_k;
        r_keep      <= n_keep;
        r_out_index <= n_out_index;
        r_out_keep  <= n_out_keep;
        r_out_full  <= n_out_full;
    end

    assign o_valid        = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_keep         = r_out_keep;
    assign o_store_full   = r_out_full;

endmodule

FILE: hw/rtl/greedy_rectangle_overlap_filter.sv
// ----------------------------------------------------------------------------
// greedy_rectangle_overlap_filter
// Greedy non-maximum suppression over rectangles in priority order.
// ----------------------------------------------------------------------------
// Each rectangle is checked against every keeper stored so far in its set,
// one stored keeper per cycle through the single read port of the kept
// store, and yields one result (index, keep, store_full). The kept store
// holds at most 1024 keepers per set; a suppressed item stops at the first
// overlap found. A two-entry input queue takes the next rectangle while the
// current one is scanned, and the result register holds while the output
// stalls. The kept store needs no clearing after reset or at the end of a
// set: only entries below the keeper count are compared. Tolerances are to
// be written at index 0 (x) and 1 (y) by the user only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module greedy_rectangle_overlap_filter import grof_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [TOL_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_x_low,
    input  logic signed [COORD_W-1:0] i_x_high,
    input  logic signed [COORD_W-1:0] i_y_low,
    input  logic signed [COORD_W-1:0] i_y_high,
    input  logic [IDX_W-1:0]          i_rect_index,
    input  logic                      i_last_of_set,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [IDX_W-1:0]          o_result_index,
    output logic                      o_keep,
    output logic                      o_store_full
);

    logic [TOL_W-1:0] r_x_tol;
    logic [TOL_W-1:0] r_y_tol;
    t_rect            in_rect;
    t_q_out           q;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_tol <= '0;
            r_y_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_X_TOL: r_x_tol <= i_cfg_data;
                REG_Y_TOL: r_y_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_rect.bounds.x_low  = i_x_low;
    assign in_rect.bounds.x_high = i_x_high;
    assign in_rect.bounds.y_low  = i_y_low;
    assign in_rect.bounds.y_high = i_y_high;
    assign in_rect.rect_index    = i_rect_index;
    assign in_rect.last_of_set   = i_last_of_set;

    grof_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_rect  (in_rect),
        .o_q     (q),
        .i_pop   (pop)
    );

    grof_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q),
        .o_pop          (pop),
        .i_x_tol        (r_x_tol),
        .i_y_tol        (r_y_tol),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_index (o_result_index),
        .o_keep         (o_keep),
        .o_store_full   (o_store_full)
    );

endmodule

FILE: hw/rtl/grof_checker.sv
// ----------------------------------------------------------------------------
// grof_checker
// Port-level checks of the overlap filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_rectangle_overlap_filter_defines.svh"

module grof_checker import grof_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [IDX_W-1:0]          o_result_index,
    input logic                      o_keep,
    input logic                      o_store_full
);

    `GROF_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_result_index) && $stable(o_keep) && $stable(o_store_full), "stalled result changed")
    `GROF_ASSERT(a_full_only_kept, i_clk, i_rst_n, o_valid |-> (o_keep || !o_store_full), "store_full on suppressed item")
    `GROF_ASSERT_RST(a_rst_no_out, i_clk, !i_rst_n |=> !o_valid, "result right after reset")
    `GROF_ASSERT_RST(a_rst_ready, i_clk, !i_rst_n |=> !o_stall, "input stalled right after reset")

endmodule

bind greedy_rectangle_overlap_filter grof_checker u_grof_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_index (o_result_index),
    .o_keep         (o_keep),
    .o_store_full   (o_store_full)
);
